/* hdl/qdfs_pkg.sv */
// ----------------------------------------------------------------------------
// qdfs_pkg
// Types, constants and helpers shared by the quoted delimiter field splitter.
// ----------------------------------------------------------------------------
package qdfs_pkg;

    // Longest line tracked; byte positions and field starts stop here.
    localparam int MAX_LINE_LEN = 4096;
    localparam int POS_W        = 13;
    localparam int CNT_W        = 13;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int MAP_W        = 256;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_LINE_LEN);
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [7:0]       QUOTE_BYTE = 8'h22;

    // Delimiter map reset: tab, LF, CR and space.
    localparam logic [MAP_W-1:0] MAP_RESET = {192'd0, 64'd4294977024};

    // Register indexes on the write port.
    localparam logic [CFG_IDX_W-1:0] REG_MAP_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_EMPTY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NO_QUOTES  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_DELIM = 3'd6;

    typedef enum logic [1:0] {
        KIND_FIELD   = 2'd0,
        KIND_DELIM   = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef struct packed {
        logic [MAP_W-1:0] delim_map;
        logic             keep_empty;
        logic             disable_quotes;
        logic             emit_delimiters;
    } t_cfg;

    typedef struct packed {
        logic             in_quote;
        logic [POS_W-1:0] field_start;
        logic [POS_W-1:0] byte_pos;
        logic [CNT_W-1:0] item_count;
        logic             overflow_seen;
    } t_line_state;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] item_start;
        logic [POS_W-1:0] item_length;
        logic [CNT_W-1:0] total_items;
        logic             overflow;
        logic             last;
    } t_result;

    // One queue entry: the results caused by one input, first in res0.
    typedef struct packed {
        t_result res0;
        t_result res1;
        logic    two;
    } t_entry;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

/* hdl/quoted_delimiter_field_splitter.sv */
// ----------------------------------------------------------------------------
// quoted_delimiter_field_splitter
// Splits a byte stream of lines into fields on a configurable delimiter set,
// honouring double-quoted stretches, and reports a summary at end of line.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         tvalid/tready                  tdata: ch; tlast: end_of_line
//  m_axis    out        tvalid/tready                  tdata: start/length/total/ovf;
//                                                      tuser: kind; tlast: last
//  cfg       in         i_cfg_we (no back-pressure)    index + 64-bit data
//
//  One byte is taken every cycle while the result queue is not full. A byte
//  is registered, split once the queue has a free entry, and its results are
//  queued. A byte causes at most two results, and the output port moves one
//  per cycle while m_axis_tready is high, so the output handshake sets the
//  sustained rate. Reset is synchronous and clears the line state, the queue
//  and the configuration to its defaults. Back-pressure on m_axis fills the
//  queue, then holds the input register and drops s_axis_tready.
// ----------------------------------------------------------------------------
module quoted_delimiter_field_splitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] ch
    input  logic                              s_axis_tlast,   // end_of_line
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [12:0] item_start, [25:13] item_length, [38:26] total_items, [39] overflow
    output logic [39:0]                       m_axis_tdata,
    output logic [1:0]                        m_axis_tuser,   // [1:0] kind
    output logic                              m_axis_tlast,   // last
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [qdfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qdfs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import qdfs_pkg::*;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_ch;
    logic        r_eol;

    // Line state and configuration
    t_line_state r_state;
    t_line_state n_state;
    t_cfg        r_cfg;

    t_entry      step_entry;
    logic        step_push;
    logic        q_full;
    logic        advance;
    t_result     head;

    // Split the held byte once the queue has a free entry.
    assign advance       = r_in_valid && !q_full;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_ch  <= s_axis_tdata;
            r_eol <= s_axis_tlast;
        end
    end

    qdfs_step u_step (
        .i_ch    (r_ch),
        .i_eol   (r_eol),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_state (n_state),
        .o_entry (step_entry),
        .o_push  (step_push)
    );

    // Commit the line state only when the byte is actually consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Configuration: writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{delim_map: MAP_RESET, keep_empty: 1'b0,
                       disable_quotes: 1'b0, emit_delimiters: 1'b0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAP_LOW:    r_cfg.delim_map[63:0]    <= i_cfg_data;
                REG_MAP_MID:    r_cfg.delim_map[127:64]  <= i_cfg_data;
                REG_MAP_HIGH:   r_cfg.delim_map[191:128] <= i_cfg_data;
                REG_MAP_TOP:    r_cfg.delim_map[255:192] <= i_cfg_data;
                REG_KEEP_EMPTY: r_cfg.keep_empty         <= i_cfg_data[0];
                REG_NO_QUOTES:  r_cfg.disable_quotes     <= i_cfg_data[0];
                REG_EMIT_DELIM: r_cfg.emit_delimiters    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    qdfs_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance && step_push),
        .i_entry (step_entry),
        .o_full  (q_full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (head)
    );

    assign m_axis_tdata = {head.overflow, head.total_items, head.item_length,
                           head.item_start};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.byte_pos <= POS_MAX)
        else $error("byte position beyond line limit");

    a_start_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.field_start <= r_state.byte_pos)
        else $error("field start ahead of byte position");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_eol) |=> (r_state.byte_pos == '0 && !r_state.in_quote
                                && r_state.item_count == '0))
        else $error("line state not cleared after end of line");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_SUMMARY) |-> m_axis_tlast)
        else $error("summary result without last");

endmodule

/* hdl/qdfs_step.sv */
// ----------------------------------------------------------------------------
// qdfs_step
// Per-byte splitting logic: next line state and the results of one byte.
// ----------------------------------------------------------------------------
module qdfs_step (
    input  logic [7:0]           i_ch,
    input  logic                 i_eol,
    input  qdfs_pkg::t_cfg        i_cfg,
    input  qdfs_pkg::t_line_state i_state,
    output qdfs_pkg::t_line_state o_state,
    output qdfs_pkg::t_entry      o_entry,
    output logic                 o_push
);
    import qdfs_pkg::*;

    logic             is_delim;
    logic             pos_sat;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] next_pos;
    logic [POS_W-1:0] len_eol;
    logic [POS_W-1:0] len_del;
    logic             ovf_now;
    logic             split;
    logic             field_eol;
    logic             field_del;
    logic             emit_d;
    logic [CNT_W-1:0] cnt_eol;
    logic [CNT_W-1:0] cnt_f;
    logic [CNT_W-1:0] cnt_fd;
    t_result          res_field;
    t_result          res_delim;
    t_result          res_sum;

    assign is_delim  = i_cfg.delim_map[i_ch];
    assign pos_sat   = (i_state.byte_pos >= POS_MAX);
    assign pos       = pos_sat ? POS_MAX : i_state.byte_pos;
    assign next_pos  = (pos == POS_MAX) ? POS_MAX : pos + POS_W'(1);
    assign len_eol   = i_state.byte_pos - i_state.field_start;
    assign len_del   = pos - i_state.field_start;
    assign ovf_now   = i_state.overflow_seen | pos_sat;
    assign split     = !i_state.in_quote && is_delim;
    assign field_eol = i_cfg.keep_empty || (len_eol != '0);
    assign field_del = i_cfg.keep_empty || (len_del != '0);
    assign emit_d    = i_cfg.emit_delimiters;

    assign cnt_eol = field_eol ? sat_inc(i_state.item_count) : i_state.item_count;
    assign cnt_f   = field_del ? sat_inc(i_state.item_count) : i_state.item_count;
    assign cnt_fd  = emit_d ? sat_inc(cnt_f) : cnt_f;

    always_comb begin
        res_field = '{kind: KIND_FIELD, item_start: i_state.field_start,
                      item_length: (i_eol ? len_eol : len_del), total_items: '0,
                      overflow: (i_eol ? i_state.overflow_seen : ovf_now),
                      last: (i_eol ? 1'b0 : !emit_d)};
        res_delim = '{kind: KIND_DELIM, item_start: pos, item_length: POS_W'(1),
                      total_items: '0, overflow: ovf_now, last: 1'b1};
        res_sum   = '{kind: KIND_SUMMARY, item_start: '0,
                      item_length: i_state.byte_pos, total_items: cnt_eol,
                      overflow: i_state.overflow_seen, last: 1'b1};

        o_state = i_state;
        o_entry = '{res0: res_field, res1: res_delim, two: 1'b0};
        o_push  = 1'b0;

        if (i_eol) begin
            o_state = '0;
            o_push  = 1'b1;
            if (field_eol) begin
                o_entry = '{res0: res_field, res1: res_sum, two: 1'b1};
            end else begin
                o_entry = '{res0: res_sum, res1: res_sum, two: 1'b0};
            end
        end else begin
            o_state.byte_pos      = next_pos;
            o_state.overflow_seen = ovf_now;
            if (split) begin
                o_state.field_start = next_pos;
                o_state.item_count  = cnt_fd;
                o_push              = field_del || emit_d;
                if (field_del) begin
                    o_entry = '{res0: res_field, res1: res_delim, two: emit_d};
                end else begin
                    o_entry = '{res0: res_delim, res1: res_delim, two: 1'b0};
                end
            end else if (!i_state.in_quote) begin
                if (!i_cfg.disable_quotes && (i_ch == QUOTE_BYTE)) begin
                    o_state.in_quote = 1'b1;
                end
            end else if (i_ch == QUOTE_BYTE) begin
                o_state.in_quote = 1'b0;
            end
        end
    end

endmodule

/* hdl/qdfs_res_queue.sv */
// ----------------------------------------------------------------------------
// qdfs_res_queue
// Result queue: takes one entry of one or two results, hands out one a cycle on i_ready.
// ----------------------------------------------------------------------------
module qdfs_res_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qdfs_pkg::t_entry  i_entry,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output qdfs_pkg::t_result o_head
);
    import qdfs_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              r_half;
    logic [QCNT_W-1:0] n_count;
    t_entry            head_entry;
    logic              fire;
    logic              deq;

    assign head_entry = r_mem[r_rd_ptr];
    assign o_valid    = (r_count != '0);
    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head     = r_half ? head_entry.res1 : head_entry.res0;
    assign fire       = o_valid && i_ready;
    // Dequeue once the second half of a pair has gone, or after a single.
    assign deq        = fire && (r_half || !head_entry.two);

    always_comb begin
        n_count = r_count;
        if (i_push && !deq) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && deq) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_half   <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (deq) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
                r_half   <= 1'b0;
            end else if (fire) begin
                r_half <= 1'b1;
            end
        end
    end

endmodule

/* tb/sv/tb_quoted_delimiter_field_splitter.sv */
// ----------------------------------------------------------------------------
// tb_quoted_delimiter_field_splitter
// Self-checking bench for the quoted delimiter field splitter. Line bytes go
// into the input stream. A line predictor works out the fields, delimiter
// items and line summaries that each byte should cause. Every transaction on
// the result stream is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_quoted_delimiter_field_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    import qdfs_pkg::*;

    // Index past the last register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // Pause that covers the pipeline depth once the last result has left.
    localparam int SETTLE_CYCLES = 8;

    // ------------------------------------------------------------------------
    // Line predictor and result checker. It keeps its own copy of the
    // register file and of the line state, and queues the results that each
    // accepted byte should cause, in order.
    // ------------------------------------------------------------------------
    class line_splitter_checker;
        logic [MAP_W-1:0] delim_set;
        logic             keep_empty;
        logic             no_quotes;
        logic             emit_delims;

        logic             in_quote;
        logic             overflow_seen;
        int unsigned      field_start;
        int unsigned      byte_pos;
        int unsigned      item_count;

        t_result          expected_results[$];
        int unsigned      mismatches;

        function new();
            delim_set   = MAP_RESET;
            keep_empty  = 1'b0;
            no_quotes   = 1'b0;
            emit_delims = 1'b0;
            mismatches  = 0;
            clear_line();
        endfunction

        function void clear_line();
            in_quote      = 1'b0;
            overflow_seen = 1'b0;
            field_start   = 0;
            byte_pos      = 0;
            item_count    = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MAP_LOW:    delim_set[63:0]    = data;
                REG_MAP_MID:    delim_set[127:64]  = data;
                REG_MAP_HIGH:   delim_set[191:128] = data;
                REG_MAP_TOP:    delim_set[255:192] = data;
                REG_KEEP_EMPTY: keep_empty  = data[0];
                REG_NO_QUOTES:  no_quotes   = data[0];
                REG_EMIT_DELIM: emit_delims = data[0];
                default: ;
            endcase
        endfunction

        // Queue one result; fields and delimiter items bump the line count.
        function void add_result(input t_kind kind, input int unsigned start,
                                 input int unsigned len, input int unsigned total);
            t_result r;
            if (kind != KIND_SUMMARY && item_count < COUNT_MAX)
                item_count++;
            r.kind        = kind;
            r.item_start  = POS_W'(start);
            r.item_length = POS_W'(len);
            r.total_items = CNT_W'(total);
            r.overflow    = overflow_seen;
            r.last        = 1'b0;
            expected_results.push_back(r);
        endfunction

        function void take_byte(input logic [7:0] ch, input logic eol);
            int unsigned queued;
            int unsigned pos;
            int unsigned next;
            int unsigned len;
            t_result     r;
            queued = expected_results.size();
            if (eol) begin
                // Flush the open field, then the summary, then start afresh.
                len = byte_pos - field_start;
                if (keep_empty || len != 0)
                    add_result(KIND_FIELD, field_start, len, 0);
                add_result(KIND_SUMMARY, 0, byte_pos, item_count);
                clear_line();
            end else begin
                pos = byte_pos;
                if (pos >= MAX_LINE_LEN) begin
                    pos           = MAX_LINE_LEN;
                    overflow_seen = 1'b1;
                end
                next = (pos + 1 > MAX_LINE_LEN) ? MAX_LINE_LEN : pos + 1;
                if (in_quote) begin
                    if (ch == QUOTE_BYTE)
                        in_quote = 1'b0;
                end else if (delim_set[ch]) begin
                    len = pos - field_start;
                    if (keep_empty || len != 0)
                        add_result(KIND_FIELD, field_start, len, 0);
                    if (emit_delims)
                        add_result(KIND_DELIM, pos, 1, 0);
                    field_start = next;
                end else if (!no_quotes && ch == QUOTE_BYTE) begin
                    in_quote = 1'b1;
                end
                byte_pos = next;
            end
            // Mark the final result of this byte.
            if (expected_results.size() > queued) begin
                r      = expected_results.pop_back();
                r.last = 1'b1;
                expected_results.push_back(r);
            end
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= 50)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(input string name, input int unsigned got,
                           input int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d, want %0d", name, got, want));
        endtask

        task check_result(input logic [39:0] data, input logic [1:0] kind,
                          input logic last);
            t_result want;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result: kind %0d start %0d length %0d",
                                 kind, data[12:0], data[25:13]));
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind",        kind,         want.kind);
            compare_field("item_start",  data[12:0],   want.item_start);
            compare_field("item_length", data[25:13],  want.item_length);
            compare_field("total_items", data[38:26],  want.total_items);
            compare_field("overflow",    data[39],     want.overflow);
            compare_field("last",        last,         want.last);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;    // [7:0] ch
    logic                  s_axis_tlast  = 1'b0;  // end_of_line
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [12:0] item_start, [25:13] item_length, [38:26] total_items, [39] overflow
    logic [39:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;          // [1:0] kind
    logic                  m_axis_tlast;          // last
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    line_splitter_checker  sb;
    bit                    idling_on = 1'b1;  // random gaps and stalls allowed
    int                    stall_left = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    quoted_delimiter_field_splitter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result side: check each transaction on the edge where it completes,
    // then pick tready for the next cycle. Stalls come in bursts of random length.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (!idling_on) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Input side tasks. Each is entered just after a rising edge; tvalid is
    // left high after a transaction so that a following item goes back to
    // back, and is lowered only by a gap or by a drain.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] ch, input logic eol);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eol;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_byte(ch, eol);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Hold the input until every predicted result has gone, then let the
    // pipeline settle so that a byte with no result is no longer in flight.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [MAP_W-1:0] map, input logic keep,
                             input logic no_quotes, input logic emit);
        drain();
        write_reg(REG_MAP_LOW,    map[63:0]);
        write_reg(REG_MAP_MID,    map[127:64]);
        write_reg(REG_MAP_HIGH,   map[191:128]);
        write_reg(REG_MAP_TOP,    map[255:192]);
        write_reg(REG_KEEP_EMPTY, CFG_DATA_W'(keep));
        write_reg(REG_NO_QUOTES,  CFG_DATA_W'(no_quotes));
        write_reg(REG_EMIT_DELIM, CFG_DATA_W'(emit));
        i_cfg_we <= 1'b0;
    endtask

    // Delimiter set with either about half or about one in eight bits set.
    function automatic logic [MAP_W-1:0] random_map(input bit sparse);
        logic [MAP_W-1:0] m;
        for (int i = 0; i < MAP_W / 32; i++)
            m[i*32 +: 32] = sparse ? ($urandom & $urandom & $urandom) : $urandom;
        return m;
    endfunction

    // Weight bytes towards delimiters and quotes so that lines break up.
    function automatic logic [7:0] pick_byte();
        int          sel;
        logic [7:0]  b;
        sel = $urandom_range(0, 99);
        b   = 8'($urandom);
        if (sel < 35) begin
            for (int tries = 0; tries < 16 && !sb.delim_set[b]; tries++)
                b = 8'($urandom);
        end else if (sel < 47) begin
            b = QUOTE_BYTE;
        end else if (sel < 50) begin
            b = 8'h00;
        end
        return b;
    endfunction

    // Random lines, mostly short with the odd longer one, each closed by an
    // end-of-line transaction whose byte is random.
    task automatic run_lines(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120)
                                               : $urandom_range(0, 24);
            for (int i = 0; i < len; i++)
                send_item(pick_byte(), 1'b0);
            send_item(8'($urandom), 1'b1);
            sent += len + 1;
            if ($urandom_range(0, 39) == 0)
                drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default delimiters (tab, LF, CR, space), no empty fields.
        // Adjacent delimiters, then a zero byte inside a field.
        send_text("ab \tc");
        send_item(8'h00, 1'b0);
        send_item(8'($urandom), 1'b1);
        // Quoted stretch hides a space; the quotes stay in the field.
        send_text("\"x y\" z");
        send_item(8'($urandom), 1'b1);
        // Quote left open at end of line; the next line must start clean.
        send_text("\"q ");
        send_item(8'($urandom), 1'b1);
        // Empty line: summary alone.
        send_item(8'($urandom), 1'b1);
        // Top-bit bytes, then line ends on a trailing LF and CR.
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_text("\n\r");
        send_item(8'($urandom), 1'b1);
        run_lines(150);

        // Every byte a delimiter, quote included; empty fields and delimiter
        // items on. The unused register index must leave all this alone.
        configure({MAP_W{1'b1}}, 1'b1, 1'b0, 1'b1);
        @(posedge i_clk);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        run_lines(150);

        // No delimiters at all and quotes off: only summaries and last fields.
        configure('0, 1'b0, 1'b1, 1'b0);
        run_lines(100);

        configure(random_map(1'b0), 1'b1, 1'b0, 1'b0);
        run_lines(250);

        configure(random_map(1'b1), 1'b0, 1'b0, 1'b1);
        run_lines(200);

        // Closing stretch at full rate on both sides.
        configure(random_map(1'($urandom_range(0, 1))), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        idling_on = 1'b0;
        run_lines(300);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* quoted_delimiter_field_splitter.f */
hdl/qdfs_pkg.sv
hdl/qdfs_step.sv
hdl/qdfs_res_queue.sv
hdl/quoted_delimiter_field_splitter.sv
tb/sv/tb_quoted_delimiter_field_splitter.sv
